// ===== sv/ookpw_pkg.sv =====
// ----------------------------------------------------------------------------
// ookpw_pkg: shared types and constants of the OOK pulse-width transmitter
// Widths, register indexes, reset values, the phase encoding and the
// command record carried between the input side and the timing engine.
// ----------------------------------------------------------------------------
package ookpw_pkg;

  localparam int CODE_BITS   = 32;
  localparam int WORD_W      = 32;
  localparam int LEN_W       = 16;
  localparam int REP_W       = 4;
  localparam int BITS_W      = $clog2(CODE_BITS + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_TDATA_W = 8;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [LEN_W-1:0] SHORT_LEN_RST    = LEN_W'(430);
  localparam logic [LEN_W-1:0] LONG_LEN_RST     = LEN_W'(1150);
  localparam logic [LEN_W-1:0] GAP_LEN_RST      = LEN_W'(8000);
  localparam logic [LEN_W-1:0] PREAMBLE_LEN_RST = LEN_W'(15000);
  localparam logic [REP_W-1:0] REPEAT_COUNT_RST = REP_W'(8);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PRE   = 3'd1,
    PH_HI    = 3'd2,
    PH_LO    = 3'd3,
    PH_TRAIL = 3'd4,
    PH_GAP   = 3'd5
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_LEN    = 3'd0,
    CFG_LONG_LEN     = 3'd1,
    CFG_GAP_LEN      = 3'd2,
    CFG_PREAMBLE_LEN = 3'd3,
    CFG_REPEAT_COUNT = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [WORD_W-1:0] code_word;
  } cmd_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
    logic              full;
  } q_status_t;

  // A zero length behaves as a single tick.
  function automatic logic [LEN_W-1:0] at_least_one(input logic [LEN_W-1:0] v);
    at_least_one = (v == '0) ? LEN_W'(1) : v;
  endfunction

endpackage

// ===== sv/ookpw_front.sv =====
// ----------------------------------------------------------------------------
// ookpw_front: input side of the transmitter
// Takes input beats, sorts them into start and tick commands and holds them
// in a short queue until the timing engine is ready for them.
// ----------------------------------------------------------------------------
module ookpw_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [ookpw_pkg::WORD_W-1:0] in_tdata,
  input  logic                         in_tuser,
  input  logic                         pop,
  output ookpw_pkg::cmd_t              head,
  output ookpw_pkg::q_status_t         status
);

  ookpw_pkg::cmd_t                   mem_r [ookpw_pkg::QDEPTH];
  logic [ookpw_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [ookpw_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [ookpw_pkg::QCNT_W-1:0]      count_r, count_nxt;
  ookpw_pkg::cmd_t                   cmd;
  logic                              push;
  logic                              do_pop;

  always_comb begin
    cmd.kind      = (in_tuser == 1'b1) ? ookpw_pkg::KIND_TICK : ookpw_pkg::KIND_START;
    // The code word only matters on a start; ticks carry zero so the
    // queue never holds stale bits.
    cmd.code_word = (in_tuser == 1'b1) ? '0 : in_tdata;
  end

  assign status.count = count_r;
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == ookpw_pkg::QCNT_W'(ookpw_pkg::QDEPTH));

  assign in_tready = !status.full;
  assign push      = in_tvalid && in_tready;
  assign do_pop    = pop && !status.empty;
  assign head      = mem_r[rd_ptr_r];

  function automatic logic [ookpw_pkg::QPTR_W-1:0] ptr_inc(
    input logic [ookpw_pkg::QPTR_W-1:0] p
  );
    ptr_inc = (p == ookpw_pkg::QPTR_W'(ookpw_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push   ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

// ===== sv/ookpw_back.sv =====
// ----------------------------------------------------------------------------
// ookpw_back: timing engine of the transmitter
// Holds the configuration registers and the phase machine, applies one queued
// command per cycle unless stalled; registers resulting pin and status flags.
// ----------------------------------------------------------------------------
module ookpw_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ookpw_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [ookpw_pkg::LEN_W-1:0]       cfg_wdata,
  input  ookpw_pkg::cmd_t                   head,
  input  ookpw_pkg::q_status_t              q_status,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ookpw_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int MSB = ookpw_pkg::CODE_BITS - 1;

  logic [ookpw_pkg::LEN_W-1:0]     short_len_r, long_len_r, gap_len_r, preamble_len_r;
  logic [ookpw_pkg::REP_W-1:0]     repeat_count_r;

  ookpw_pkg::phase_t                phase_r, phase_nxt;
  logic [ookpw_pkg::LEN_W-1:0]      time_left_r, time_left_nxt;
  logic [MSB:0]                     bit_shift_r, bit_shift_nxt;
  logic [ookpw_pkg::BITS_W-1:0]     bits_left_r, bits_left_nxt;
  logic [ookpw_pkg::REP_W-1:0]      repeats_left_r, repeats_left_nxt;
  logic [MSB:0]                     frame_word_r, frame_word_nxt;

  logic                             out_valid_r;
  logic [ookpw_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic                             finished;
  logic                             dropped;
  logic [ookpw_pkg::LEN_W-1:0]      time_dec;
  logic [MSB:0]                     shifted;
  logic [ookpw_pkg::BITS_W-1:0]     bits_dec;
  logic [ookpw_pkg::REP_W-1:0]      reps_dec;
  logic [MSB:0]                     new_frame;

  assign pop        = !q_status.empty && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_len_r    <= ookpw_pkg::SHORT_LEN_RST;
      long_len_r     <= ookpw_pkg::LONG_LEN_RST;
      gap_len_r      <= ookpw_pkg::GAP_LEN_RST;
      preamble_len_r <= ookpw_pkg::PREAMBLE_LEN_RST;
      repeat_count_r <= ookpw_pkg::REPEAT_COUNT_RST;
    end else if (cfg_we) begin
      case (ookpw_pkg::cfg_idx_t'(cfg_addr))
        ookpw_pkg::CFG_SHORT_LEN:    short_len_r    <= cfg_wdata;
        ookpw_pkg::CFG_LONG_LEN:     long_len_r     <= cfg_wdata;
        ookpw_pkg::CFG_GAP_LEN:      gap_len_r      <= cfg_wdata;
        ookpw_pkg::CFG_PREAMBLE_LEN: preamble_len_r <= cfg_wdata;
        ookpw_pkg::CFG_REPEAT_COUNT: repeat_count_r <= cfg_wdata[ookpw_pkg::REP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    time_left_nxt    = time_left_r;
    bit_shift_nxt    = bit_shift_r;
    bits_left_nxt    = bits_left_r;
    repeats_left_nxt = repeats_left_r;
    frame_word_nxt   = frame_word_r;
    finished         = 1'b0;
    dropped          = 1'b0;
    time_dec         = time_left_r - 1'b1;
    shifted          = bit_shift_r << 1;
    bits_dec         = bits_left_r - 1'b1;
    reps_dec         = repeats_left_r - 1'b1;
    new_frame        = ookpw_pkg::CODE_BITS'(head.code_word);

    if (pop) begin
      if (head.kind == ookpw_pkg::KIND_START) begin
        if (phase_r != ookpw_pkg::PH_IDLE) begin
          dropped = 1'b1;
        end else begin
          frame_word_nxt   = new_frame;
          repeats_left_nxt = (repeat_count_r == '0) ? ookpw_pkg::REP_W'(1) : repeat_count_r;
          if (preamble_len_r != '0) begin
            phase_nxt     = ookpw_pkg::PH_PRE;
            time_left_nxt = preamble_len_r;
          end else begin
            // No preamble: go straight into the first bit's high pulse.
            bit_shift_nxt = new_frame;
            bits_left_nxt = ookpw_pkg::BITS_W'(ookpw_pkg::CODE_BITS);
            phase_nxt     = ookpw_pkg::PH_HI;
            time_left_nxt = ookpw_pkg::at_least_one(new_frame[MSB] ? long_len_r : short_len_r);
          end
        end
      end else if (phase_r != ookpw_pkg::PH_IDLE) begin
        time_left_nxt = time_dec;
        if (time_dec == '0) begin
          case (phase_r)
            ookpw_pkg::PH_PRE: begin
              bit_shift_nxt = frame_word_r;
              bits_left_nxt = ookpw_pkg::BITS_W'(ookpw_pkg::CODE_BITS);
              phase_nxt     = ookpw_pkg::PH_HI;
              time_left_nxt = ookpw_pkg::at_least_one(
                                frame_word_r[MSB] ? long_len_r : short_len_r);
            end
            ookpw_pkg::PH_HI: begin
              phase_nxt     = ookpw_pkg::PH_LO;
              time_left_nxt = ookpw_pkg::at_least_one(
                                bit_shift_r[MSB] ? short_len_r : long_len_r);
            end
            ookpw_pkg::PH_LO: begin
              bit_shift_nxt = shifted;
              bits_left_nxt = bits_dec;
              if (bits_dec != '0) begin
                phase_nxt     = ookpw_pkg::PH_HI;
                time_left_nxt = ookpw_pkg::at_least_one(
                                  shifted[MSB] ? long_len_r : short_len_r);
              end else begin
                phase_nxt     = ookpw_pkg::PH_TRAIL;
                time_left_nxt = ookpw_pkg::at_least_one(short_len_r);
              end
            end
            ookpw_pkg::PH_TRAIL: begin
              phase_nxt     = ookpw_pkg::PH_GAP;
              time_left_nxt = ookpw_pkg::at_least_one(gap_len_r);
            end
            ookpw_pkg::PH_GAP: begin
              repeats_left_nxt = reps_dec;
              if (reps_dec != '0) begin
                bit_shift_nxt = frame_word_r;
                bits_left_nxt = ookpw_pkg::BITS_W'(ookpw_pkg::CODE_BITS);
                phase_nxt     = ookpw_pkg::PH_HI;
                time_left_nxt = ookpw_pkg::at_least_one(
                                  frame_word_r[MSB] ? long_len_r : short_len_r);
              end else begin
                phase_nxt = ookpw_pkg::PH_IDLE;
                finished  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= ookpw_pkg::PH_IDLE;
      time_left_r    <= '0;
      bit_shift_r    <= '0;
      bits_left_r    <= '0;
      repeats_left_r <= '0;
      frame_word_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      time_left_r    <= time_left_nxt;
      bit_shift_r    <= bit_shift_nxt;
      bits_left_r    <= bits_left_nxt;
      repeats_left_r <= repeats_left_nxt;
      frame_word_r   <= frame_word_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= {4'b0000, dropped, finished,
                     (phase_nxt != ookpw_pkg::PH_IDLE),
                     (phase_nxt == ookpw_pkg::PH_HI || phase_nxt == ookpw_pkg::PH_TRAIL)};
    end
  end

endmodule

// ===== sv/ook_pulse_width_code_transmitter_top.sv =====
// ----------------------------------------------------------------------------
// ook_pulse_width_code_transmitter_top: pulse-width coded OOK transmitter
// Sends a 32-bit code as a low preamble and repeated pulse-width frames.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock while the queue is not full,
// either a start carrying the code word or a one-microsecond tick, and
// returns exactly one result beat per input beat with the pin level and
// status after that beat. Beats pass a two-entry queue and then the timing
// engine, which applies one command per cycle while the output is not
// stalled, so the sustained rate is one beat per clock. A beat is held in
// the queue memory and its result in the output register. Registers should
// only be written while no transmission is running.
module ook_pulse_width_code_transmitter_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ookpw_pkg::WORD_W-1:0]      in_tdata,   // [31:0] code_word
  input  logic                              in_tuser,   // [0] kind (0 start, 1 tick)
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] pin_level, [1] busy_res, [2] finished, [3] start_dropped, [7:4] zero
  output logic [ookpw_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                              cfg_we,
  input  logic [ookpw_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [ookpw_pkg::LEN_W-1:0]       cfg_wdata
);

  ookpw_pkg::cmd_t      head;
  ookpw_pkg::q_status_t q_status;
  logic                 pop;

  ookpw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  ookpw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  // The engine never takes a command from an empty queue.
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("command taken from empty queue");

  // A stalled result must not be overwritten by a new command.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !pop)
    else $error("result overwritten while stalled");

  // Queue occupancy only moves by one per beat and never passes its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.count <= ookpw_pkg::QCNT_W'(ookpw_pkg::QDEPTH))
    else $error("queue overfilled");

  // A finished beat ends the transmission and the pin is low with it.
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2]) |-> (!out_tdata[1] && !out_tdata[0]))
    else $error("finished reported while still busy");
`endif

endmodule
